### hdl/tdms_pkg.sv
// ----------------------------------------------------------------------------
// tdms_pkg: shared types and constants of the timed mode sequencer.
// Holds the opcode set, the register indexes, the reset values of the
// registers and the layout of one mode table entry.
// ----------------------------------------------------------------------------
package tdms_pkg;

	// Opcodes of an input item. Code 3 has no meaning and is ignored.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_POWER = 2'd1,
		OP_WRITE = 2'd2
	} tdms_op_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LONG_CLICK_TICKS = 3'd0;
	localparam logic [2:0] CFG_LONG_OFF_TICKS   = 3'd1;
	localparam logic [2:0] CFG_FAN_PULSE_TICKS  = 3'd2;
	localparam logic [2:0] CFG_LONG_CLICK_MODE  = 3'd3;
	localparam logic [2:0] CFG_LONG_OFF_MODE    = 3'd4;

	// Register values after reset.
	localparam logic [31:0] RST_LONG_CLICK_TICKS = 32'd14062;
	localparam logic [31:0] RST_LONG_OFF_TICKS   = 32'd46875;
	localparam logic [15:0] RST_FAN_PULSE_TICKS  = 16'd468;

	// Blink patterns advance one bit every 2^PATTERN_SHIFT ticks.
	localparam int PATTERN_SHIFT = 9;

	// One mode table entry, 57 bits. Next-mode fields are kept as written.
	typedef struct packed {
		logic        fan;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [31:0] timeout;
		logic [3:0]  timeout_next;
		logic [3:0]  press_next;
	} tdms_entry_t;

endpackage

### hdl/tdms_mode_ram.sv
// ----------------------------------------------------------------------------
// tdms_mode_ram: mode table storage.
// One write port and one read port with registered read data. A write to
// the address being read in the same cycle is passed through to the output.
// ----------------------------------------------------------------------------
module tdms_mode_ram #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  tdms_pkg::tdms_entry_t wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output tdms_pkg::tdms_entry_t rdata
);
	import tdms_pkg::*;

	tdms_entry_t mem_q [DEPTH];
	tdms_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rd_q <= wdata;
		end else begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

### hdl/table_driven_timed_mode_sequencer.sv
// ----------------------------------------------------------------------------
// table_driven_timed_mode_sequencer: table-driven timed mode sequencer.
// Ticks pass the input register, then the result register. Throughput: one
// item per cycle while not stalled; the mode table read port, addressed by
// the next mode, returns the new mode's entry in time for the following tick.
// Reset presets control state and the registers; the mode table is undefined.
// ----------------------------------------------------------------------------
module table_driven_timed_mode_sequencer #(
	parameter int MODE_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        button_pressed,
	input  logic        power_on,
	input  logic [3:0]  entry_index,
	input  logic        entry_fan,
	input  logic [7:0]  entry_red,
	input  logic [7:0]  entry_green,
	input  logic [31:0] entry_timeout,
	input  logic [3:0]  entry_timeout_next,
	input  logic [3:0]  entry_press_next,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        led_red,
	output logic        led_green,
	output logic        fan_drive,
	output logic [3:0]  mode_now,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tdms_pkg::*;

	// Width of a mode index inside the block.
	localparam int MW = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;

	// Reduces a 4-bit mode number modulo MODE_COUNT by repeated subtraction.
	// Eight steps cover the smallest table of two modes.
	function automatic logic [MW-1:0] wrap_mode(input logic [3:0] v);
		logic [8:0] r;
		r = {5'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= 9'(MODE_COUNT)) begin
				r = r - 9'(MODE_COUNT);
			end
		end
		return MW'(r);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back; writes are to be
	// made only while the block is idle, which the block does not enforce.
	// Mode registers are stored already reduced to a table index.
	// ------------------------------------------------------------------
	logic [31:0]   long_click_ticks_q;
	logic [31:0]   long_off_ticks_q;
	logic [15:0]   fan_pulse_ticks_q;
	logic [MW-1:0] long_click_mode_q;
	logic [MW-1:0] long_off_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_click_ticks_q <= RST_LONG_CLICK_TICKS;
			long_off_ticks_q   <= RST_LONG_OFF_TICKS;
			fan_pulse_ticks_q  <= RST_FAN_PULSE_TICKS;
			long_click_mode_q  <= '0;
			long_off_mode_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LONG_CLICK_TICKS: long_click_ticks_q <= cfg_data;
				CFG_LONG_OFF_TICKS:   long_off_ticks_q   <= cfg_data;
				CFG_FAN_PULSE_TICKS:  fan_pulse_ticks_q  <= cfg_data[15:0];
				CFG_LONG_CLICK_MODE:  long_click_mode_q  <= wrap_mode(cfg_data[3:0]);
				CFG_LONG_OFF_MODE:    long_off_mode_q    <= wrap_mode(cfg_data[3:0]);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control. Stage 1 is the input register; stage 2 is the result
	// register. Stage 2's outputs are formed from its own bits and from the
	// table entry of the current mode, so the sequencer state and the
	// entry only move when stage 2 is empty or its result transfers out.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic advance;
	logic in_xfer;
	logic proc_s1;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign proc_s1  = valid_s1 && advance;

	// Stage 1 payload.
	logic [1:0]  op_s1;
	logic        button_s1;
	logic        power_s1;
	logic [3:0]  index_s1;
	tdms_entry_t entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1                 <= opcode;
			button_s1             <= button_pressed;
			power_s1              <= power_on;
			index_s1              <= entry_index;
			entry_s1.fan          <= entry_fan;
			entry_s1.red          <= entry_red;
			entry_s1.green        <= entry_green;
			entry_s1.timeout      <= entry_timeout;
			entry_s1.timeout_next <= entry_timeout_next;
			entry_s1.press_next   <= entry_press_next;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state.
	// ------------------------------------------------------------------
	logic [MW-1:0] mode_q;
	logic [31:0]   tick_count_q;
	logic [31:0]   last_count_q;
	logic          last_button_q;
	logic [15:0]   fan_remaining_q;

	logic [MW-1:0] mode_d;
	logic [31:0]   tick_count_d;
	logic [31:0]   last_count_d;
	logic          last_button_d;
	logic [15:0]   fan_remaining_d;
	logic          fan_active;

	// Entry of the current mode, read from the table at the address that
	// became the current mode, so it is registered along with mode_q.
	tdms_entry_t cur_entry;

	logic        is_tick;
	logic        is_power;
	logic        is_write;
	logic        index_ok;
	logic [31:0] tick_inc;
	logic        held;

	assign is_tick  = proc_s1 && (op_s1 == OP_TICK);
	assign is_power = proc_s1 && (op_s1 == OP_POWER);
	assign is_write = proc_s1 && (op_s1 == OP_WRITE);
	assign index_ok = ({5'b0, index_s1} < 9'(MODE_COUNT));

	// The tick counter saturates at its top value.
	assign tick_inc = (tick_count_q == '1) ? tick_count_q : tick_count_q + 32'd1;
	assign held     = button_s1 && last_button_q;

	always_comb begin
		mode_d          = mode_q;
		tick_count_d    = tick_count_q;
		last_count_d    = last_count_q;
		last_button_d   = last_button_q;
		fan_remaining_d = fan_remaining_q;
		fan_active      = 1'b0;
		if (is_tick) begin
			// The first rule that applies wins: very long hold, long click,
			// press edge, then timeout of the current mode.
			tick_count_d = tick_inc;
			if (held && (tick_inc >= long_off_ticks_q)) begin
				mode_d = long_off_mode_q;
			end else if (held && (tick_inc >= long_click_ticks_q)) begin
				mode_d = long_click_mode_q;
			end else if (button_s1 && !last_button_q) begin
				mode_d       = wrap_mode(cur_entry.press_next);
				tick_count_d = '0;
			end else if (last_count_q >= cur_entry.timeout) begin
				mode_d       = wrap_mode(cur_entry.timeout_next);
				tick_count_d = '0;
			end
			// The fan follows the new mode only while a pulse is running.
			if (fan_remaining_q != '0) begin
				fan_active      = 1'b1;
				fan_remaining_d = fan_remaining_q - 16'd1;
			end
			last_button_d = button_s1;
			last_count_d  = tick_count_d;
		end else if (is_power) begin
			fan_remaining_d = fan_pulse_ticks_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= '0;
			tick_count_q    <= '0;
			last_count_q    <= '0;
			last_button_q   <= 1'b0;
			fan_remaining_q <= '0;
		end else begin
			mode_q          <= mode_d;
			tick_count_q    <= tick_count_d;
			last_count_q    <= last_count_d;
			last_button_q   <= last_button_d;
			fan_remaining_q <= fan_remaining_d;
		end
	end

	// ------------------------------------------------------------------
	// Mode table. It is read at the next mode, so when a tick moves into
	// stage 2 the entry of its new mode arrives with it, and the same entry
	// serves as the current mode of the tick that follows.
	// ------------------------------------------------------------------
	tdms_mode_ram #(
		.DEPTH  (MODE_COUNT),
		.ADDR_W (MW)
	) u_mode_ram (
		.clk   (clk),
		.we    (is_write && index_ok),
		.waddr (MW'(index_s1)),
		.wdata (entry_s1),
		.raddr (mode_d),
		.rdata (cur_entry)
	);

	// ------------------------------------------------------------------
	// Stage 2: result register. The pattern position comes from the count
	// before this tick.
	// ------------------------------------------------------------------
	logic [2:0] bitpos_s2;
	logic       power_s2;
	logic       fan_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			bitpos_s2 <= last_count_q[PATTERN_SHIFT +: 3];
			power_s2  <= power_s1;
			fan_s2    <= fan_active;
		end
	end

	// LEDs are gated by the power level seen with the tick.
	assign out_valid = valid_s2;
	assign led_red   = power_s2 && cur_entry.red[bitpos_s2];
	assign led_green = power_s2 && cur_entry.green[bitpos_s2];
	assign fan_drive = fan_s2 && cur_entry.fan;
	assign mode_now  = 4'(mode_q);

endmodule

### tb/sv/tdms_checker.sv
// ----------------------------------------------------------------------------
// tdms_checker: result predictor and scoreboard for the timed mode sequencer.
// Watches the input, output and register channels, keeps its own copy of the
// mode table, the registers and the tick state, and compares every output
// transfer with the oldest predicted tick result.
// ----------------------------------------------------------------------------
module tdms_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        button_pressed,
	input  logic        power_on,
	input  logic [3:0]  entry_index,
	input  logic        entry_fan,
	input  logic [7:0]  entry_red,
	input  logic [7:0]  entry_green,
	input  logic [31:0] entry_timeout,
	input  logic [3:0]  entry_timeout_next,
	input  logic [3:0]  entry_press_next,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        led_red,
	input  logic        led_green,
	input  logic        fan_drive,
	input  logic [3:0]  mode_now,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tdms_pkg::*;

	typedef struct packed {
		logic       red;
		logic       green;
		logic       fan;
		logic [3:0] mode;
	} tick_result_t;

	tick_result_t expected_ticks[$];
	int           mismatches;

	logic [31:0] long_click_ticks;
	logic [31:0] long_off_ticks;
	logic [15:0] fan_pulse_ticks;
	logic [3:0]  long_click_mode;
	logic [3:0]  long_off_mode;

	logic [3:0]  mode_idx;
	logic [31:0] tick_count;
	logic [31:0] prev_count;
	logic        prev_button;
	logic [15:0] fan_left;
	tdms_entry_t mode_table [16];

	// Advances the sequencer by one tick and queues the LED, fan and mode
	// values that the block must show for it.
	task automatic predict_tick(input logic button, input logic power);
		tdms_entry_t  cur;
		logic [2:0]   bitpos;
		tick_result_t res;
		logic         held;
		held = button && prev_button;
		if (tick_count != '1)
			tick_count++;
		cur = mode_table[mode_idx];
		if (held && tick_count >= long_off_ticks) begin
			mode_idx = long_off_mode;
		end else if (held && tick_count >= long_click_ticks) begin
			mode_idx = long_click_mode;
		end else if (button && !prev_button) begin
			mode_idx = cur.press_next;
			tick_count = '0;
		end else if (prev_count >= cur.timeout) begin
			mode_idx = cur.timeout_next;
			tick_count = '0;
		end
		cur = mode_table[mode_idx];
		bitpos = prev_count[PATTERN_SHIFT +: 3];
		res.red = power & cur.red[bitpos];
		res.green = power & cur.green[bitpos];
		if (fan_left != '0) begin
			res.fan = cur.fan;
			fan_left--;
		end else begin
			res.fan = 1'b0;
		end
		res.mode = mode_idx;
		prev_button = button;
		prev_count = tick_count;
		expected_ticks.push_back(res);
	endtask

	task automatic compare_result();
		tick_result_t want;
		if (expected_ticks.size() == 0) begin
			$error("unexpected result transfer: mode_now %0d", mode_now);
			mismatches++;
		end else begin
			want = expected_ticks.pop_front();
			if (led_red !== want.red) begin
				$error("led_red: expected %0d, actual %0d", want.red, led_red);
				mismatches++;
			end
			if (led_green !== want.green) begin
				$error("led_green: expected %0d, actual %0d", want.green, led_green);
				mismatches++;
			end
			if (fan_drive !== want.fan) begin
				$error("fan_drive: expected %0d, actual %0d", want.fan, fan_drive);
				mismatches++;
			end
			if (mode_now !== want.mode) begin
				$error("mode_now: expected %0d, actual %0d", want.mode, mode_now);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_click_ticks = RST_LONG_CLICK_TICKS;
			long_off_ticks = RST_LONG_OFF_TICKS;
			fan_pulse_ticks = RST_FAN_PULSE_TICKS;
			long_click_mode = '0;
			long_off_mode = '0;
			mode_idx = '0;
			tick_count = '0;
			prev_count = '0;
			prev_button = 1'b0;
			fan_left = '0;
			for (int i = 0; i < 16; i++)
				mode_table[i] = '0;
			expected_ticks.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LONG_CLICK_TICKS: long_click_ticks = cfg_data;
					CFG_LONG_OFF_TICKS:   long_off_ticks = cfg_data;
					CFG_FAN_PULSE_TICKS:  fan_pulse_ticks = cfg_data[15:0];
					CFG_LONG_CLICK_MODE:  long_click_mode = cfg_data[3:0];
					CFG_LONG_OFF_MODE:    long_off_mode = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_TICK:  predict_tick(button_pressed, power_on);
					OP_POWER: fan_left = fan_pulse_ticks;
					OP_WRITE: mode_table[entry_index] = '{entry_fan, entry_red, entry_green,
						entry_timeout, entry_timeout_next, entry_press_next};
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				compare_result();
		end
		fail_count <= mismatches;
		pending <= expected_ticks.size();
	end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench top for the table-driven timed mode sequencer.
// Loads the mode table, then runs directed and random ticks, power changes
// and table writes under several register settings and traffic patterns.
// A checker beside the block predicts and compares every tick result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tdms_pkg::*;

	// Opcode 3 carries no meaning; the block must drop it silently.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles without any transfer before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Cycles allowed after the last result before registers are touched.
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        button;
		logic        power;
		logic [3:0]  index;
		logic        fan;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [31:0] timeout;
		logic [3:0]  timeout_next;
		logic [3:0]  press_next;
	} seq_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic        button_pressed;
	logic        power_on;
	logic [3:0]  entry_index;
	logic        entry_fan;
	logic [7:0]  entry_red;
	logic [7:0]  entry_green;
	logic [31:0] entry_timeout;
	logic [3:0]  entry_timeout_next;
	logic [3:0]  entry_press_next;
	logic        out_valid;
	logic        out_stall;
	logic        led_red;
	logic        led_green;
	logic        fan_drive;
	logic [3:0]  mode_now;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int fail_count;
	int pending;

	// Traffic shaping: percentage of cycles in which the sender holds back
	// and the receiver stalls. While quiet is set, neither side idles, so
	// runs of back-to-back transfers appear inside every idling regime.
	int   idle_pct;
	int   stall_pct;
	logic quiet;
	int   quiet_timer;
	int   idle_cycles;

	// 4 ns clock, high then low.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	table_driven_timed_mode_sequencer dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.button_pressed     (button_pressed),
		.power_on           (power_on),
		.entry_index        (entry_index),
		.entry_fan          (entry_fan),
		.entry_red          (entry_red),
		.entry_green        (entry_green),
		.entry_timeout      (entry_timeout),
		.entry_timeout_next (entry_timeout_next),
		.entry_press_next   (entry_press_next),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.led_red            (led_red),
		.led_green          (led_green),
		.fan_drive          (fan_drive),
		.mode_now           (mode_now),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	tdms_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.button_pressed     (button_pressed),
		.power_on           (power_on),
		.entry_index        (entry_index),
		.entry_fan          (entry_fan),
		.entry_red          (entry_red),
		.entry_green        (entry_green),
		.entry_timeout      (entry_timeout),
		.entry_timeout_next (entry_timeout_next),
		.entry_press_next   (entry_press_next),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.led_red            (led_red),
		.led_green          (led_green),
		.fan_drive          (fan_drive),
		.mode_now           (mode_now),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.fail_count         (fail_count),
		.pending            (pending)
	);

	// The quiet window is re-rolled by a timer. It changes on the rising
	// edge so that the falling-edge drivers always read a settled value.
	always @(posedge clk) begin
		if (quiet_timer == 0) begin
			quiet <= ($urandom_range(99) < 25);
			quiet_timer <= 50;
		end else begin
			quiet_timer <= quiet_timer - 1;
		end
	end

	// The receiver decides its stall for the next edge at each falling edge.
	always @(negedge clk) begin
		out_stall = !quiet && ($urandom_range(99) < stall_pct);
	end

	// Watchdog: any transfer on any channel proves the block is alive.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Fields that the opcode does not use are filled with noise, since the
	// block has to ignore them.
	function automatic seq_item_t noise_item();
		seq_item_t it;
		it.opcode = 2'($urandom_range(3));
		it.button = 1'($urandom_range(1));
		it.power = 1'($urandom_range(1));
		it.index = 4'($urandom_range(15));
		it.fan = 1'($urandom_range(1));
		it.red = 8'($urandom_range(255));
		it.green = 8'($urandom_range(255));
		it.timeout = $urandom;
		it.timeout_next = 4'($urandom_range(15));
		it.press_next = 4'($urandom_range(15));
		return it;
	endfunction

	// Mostly short timeouts so that modes keep moving, with some long and
	// some full-range ones that only a press or a long hold can leave.
	function automatic logic [31:0] pick_timeout();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return $urandom_range(30);
		else if (roll < 85)
			return $urandom_range(600);
		else
			return $urandom;
	endfunction

	// Offers one item and returns at the falling edge after its transfer.
	// A sender gap is only ever taken before the item is offered, so valid
	// never reacts to stall and the offered payload stays put while stalled.
	task automatic send_item(input seq_item_t it);
		while (!quiet && $urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = it.opcode;
		button_pressed = it.button;
		power_on = it.power;
		entry_index = it.index;
		entry_fan = it.fan;
		entry_red = it.red;
		entry_green = it.green;
		entry_timeout = it.timeout;
		entry_timeout_next = it.timeout_next;
		entry_press_next = it.press_next;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_tick(input logic button, input logic power);
		seq_item_t it;
		it = noise_item();
		it.opcode = OP_TICK;
		it.button = button;
		it.power = power;
		send_item(it);
	endtask

	task automatic send_entry(input logic [3:0] index, input logic [31:0] timeout);
		seq_item_t it;
		it = noise_item();
		it.opcode = OP_WRITE;
		it.index = index;
		it.timeout = timeout;
		send_item(it);
	endtask

	// Drains the block before a register write: every predicted tick result
	// must be out, then a short pause covers power and table transfers that
	// produce no result but may still be in flight.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
		cfg_index = index;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Writes all five registers. Mode registers get noise above their four
	// meaningful bits, which the block must drop.
	task automatic load_registers(input logic [31:0] click_ticks, input logic [31:0] off_ticks,
		input logic [15:0] pulse_ticks, input logic [3:0] click_mode,
		input logic [3:0] off_mode);
		write_reg(CFG_LONG_CLICK_TICKS, click_ticks);
		write_reg(CFG_LONG_OFF_TICKS, off_ticks);
		write_reg(CFG_FAN_PULSE_TICKS, {16'($urandom), pulse_ticks});
		write_reg(CFG_LONG_CLICK_MODE, {28'($urandom), click_mode});
		write_reg(CFG_LONG_OFF_MODE, {28'($urandom), off_mode});
	endtask

	// Random traffic: runs of ticks with a mostly steady button, long button
	// holds that reach the long-click and long-hold rules, power changes,
	// table rewrites, ignored opcodes and fully random ticks.
	task automatic run_random(input int count);
		int        done;
		int        kind;
		int        len;
		logic      level;
		seq_item_t it;
		done = 0;
		level = 1'b0;
		while (done < count) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				len = $urandom_range(1, 12);
				repeat (len) begin
					if ($urandom_range(99) < 20)
						level = !level;
					send_tick(level, $urandom_range(99) < 75);
				end
				done += len;
			end else if (kind < 62) begin
				len = $urandom_range(1, 30);
				repeat (len)
					send_tick(1'b1, 1'($urandom_range(1)));
				send_tick(1'b0, 1'($urandom_range(1)));
				level = 1'b0;
				done += len + 1;
			end else if (kind < 70) begin
				it = noise_item();
				it.opcode = OP_POWER;
				send_item(it);
				done++;
			end else if (kind < 86) begin
				send_entry(4'($urandom_range(15)), pick_timeout());
				done++;
			end else if (kind < 92) begin
				// Ignored by the block, so it does not count as an item.
				it = noise_item();
				it.opcode = OP_UNUSED;
				send_item(it);
			end else begin
				it = noise_item();
				it.opcode = OP_TICK;
				send_item(it);
				done++;
			end
		end
	endtask

	initial begin
		seq_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		button_pressed = 1'b0;
		power_on = 1'b0;
		entry_index = '0;
		entry_fan = 1'b0;
		entry_red = '0;
		entry_green = '0;
		entry_timeout = '0;
		entry_timeout_next = '0;
		entry_press_next = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 14;
		stall_pct = 55;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, under the reset register values. The table has no
		// defined contents after reset, so every entry is loaded before the
		// first tick reads one. Entry 0 has all red and no green and expires
		// at once; entry 15 has all green and a timeout that never expires.
		for (int i = 0; i < 16; i++) begin
			it = noise_item();
			it.opcode = OP_WRITE;
			it.index = 4'(i);
			it.fan = i[0];
			it.red = (i == 0) ? 8'hFF : (i == 15) ? 8'h00 : {4'(i), ~4'(i)};
			it.green = (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : {~4'(i), 4'(i)};
			it.timeout = (i == 15) ? 32'hFFFF_FFFF : i;
			it.timeout_next = 4'(i + 1);
			it.press_next = 4'(15 - i);
			send_item(it);
		end
		// A power change starts the fan pulse for the ticks that follow.
		it = noise_item();
		it.opcode = OP_POWER;
		send_item(it);
		// Timeout of zero, then a press edge, a held button with LEDs off,
		// and a release.
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		// An unused opcode must leave no trace.
		it = noise_item();
		it.opcode = OP_UNUSED;
		send_item(it);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);

		// Short long-click and long-hold thresholds that a few dozen held
		// ticks cross, with a short fan pulse.
		wait_drained();
		load_registers(32'd6, 32'd15, 16'd4, 4'($urandom_range(15)),
			4'($urandom_range(15)));
		run_random(200);

		// Swap the idling sides. Any held tick is a long click now, the long
		// hold never fires, and a power change gives no fan pulse.
		wait_drained();
		idle_pct = 55;
		stall_pct = 14;
		load_registers(32'd0, 32'hFFFF_FFFF, 16'd0, 4'd15, 4'd0);
		run_random(170);

		// No idling. Any held tick is a long hold and the fan pulse is as
		// long as it gets.
		wait_drained();
		idle_pct = 0;
		stall_pct = 0;
		load_registers(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 4'd0, 4'd15);
		run_random(170);

		// A long dwell in one mode walks the blink pattern through its first
		// three bit positions: every entry gets a timeout longer than the
		// dwell, and the button stays released.
		for (int i = 0; i < 16; i++)
			send_entry(4'(i), 32'd5000);
		it = noise_item();
		it.opcode = OP_POWER;
		send_item(it);
		repeat (1100)
			send_tick(1'b0, $urandom_range(99) < 90);
		run_random(10);

		wait_drained();
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
